[hdl/bqr_pkg.sv]
`default_nettype none

package bqr_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned FillW  = 8;

  // operation codes carried in tuser on the input side
  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_e;

  // result status carried in tuser on the output side
  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT,
    CELL_MATCH,
    CELL_REMOVE
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e          cmd;
    logic [ValueW-1:0]  value;
  } cell_ctrl_t;

  typedef struct packed {
    status_e            status;
    logic [ValueW-1:0]  value;
    logic [FillW-1:0]   fill;
  } result_t;

endpackage

`default_nettype wire

[hdl/bqr_cell.sv]
`default_nettype none

module bqr_cell
  import bqr_pkg::*;
(
  input  wire                clk_i,
  input  cell_ctrl_t         ctrl_i,
  input  wire                load_en_i,
  input  wire                in_range_i,
  input  wire [ValueW-1:0]   next_data_i,
  input  wire                prior_i,
  output logic [ValueW-1:0]  data_o,
  output logic               prior_o
);

  logic [ValueW-1:0] data_q;
  logic              match_q;

  // a match here or in any cell nearer the head
  assign prior_o = prior_i | match_q;
  assign data_o  = data_q;

  // entry storage and compare flag
  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      CELL_LOAD: begin
        if (load_en_i) begin
          data_q <= ctrl_i.value;
        end
      end
      CELL_SHIFT: begin
        data_q <= next_data_i;
      end
      CELL_MATCH: begin
        match_q <= in_range_i && (data_q == ctrl_i.value);
      end
      CELL_REMOVE: begin
        if (prior_o) begin
          data_q <= next_data_i;
        end
        match_q <= 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/bqr_outbuf.sv]
`default_nettype none

module bqr_outbuf
  import bqr_pkg::*;
(
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      push_i,
  input  result_t  res_i,
  output logic     full_o,
  output logic     valid_o,
  input  wire      ready_i,
  output result_t  res_o
);

  logic [1:0] cnt_q, cnt_d;
  result_t    slot0_q, slot1_q;
  logic       pop;

  assign pop     = (cnt_q != 2'd0) && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign res_o   = slot0_q;

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // two result slots, head in slot0
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (push_i && cnt_q == 2'd1) begin
        slot0_q <= res_i;
      end else begin
        slot0_q <= slot1_q;
      end
      if (push_i && cnt_q == 2'd2) begin
        slot1_q <= res_i;
      end
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        slot0_q <= res_i;
      end else begin
        slot1_q <= res_i;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/bounded_queue_with_remove_by_value.sv]
// channel | direction | tdata (low bit up)        | tuser
// s_      | in        | value[31:0]               | mode[1:0]
// m_      | out       | out_value[31:0], fill[39:32] | status[1:0]
//
// push and pop change the queue at the edge of their input transfer; remove
// compares in that cycle and unlinks the first match in the next, set by the
// registered compare flag in each cell.
// the result is registered in res_q and then written into a two-slot buffer, so
// m_tvalid_o rises only after both, and a remove first passes through S_REMOVE.
// s_tready_o drops for the cycle after each transfer and through a remove, so
// no new transfer is taken before the last result has left res_q; it also stays
// low while both buffer slots hold results waiting on m_tready_i.
// reset clears the fill count and the state; the entry cells are not cleared.
`default_nettype none

module bounded_queue_with_remove_by_value
  import bqr_pkg::*;
#(
  parameter int unsigned CAPACITY = 128
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_tvalid_i,
  output logic        s_tready_o,
  input  wire  [31:0] s_tdata_i,   // value[31:0]
  input  wire  [1:0]  s_tuser_i,   // mode[1:0]
  output logic        m_tvalid_o,
  input  wire         m_tready_i,
  output logic [39:0] m_tdata_o,   // out_value[31:0], fill[39:32]
  output logic [1:0]  m_tuser_o    // status[1:0]
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic {
    S_IDLE,
    S_REMOVE
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [ValueW-1:0] srch_q, srch_d;
  logic              res_push_q, res_push_d;
  result_t           res_q, res_d;

  cell_ctrl_t        ctrl;
  logic              accept;
  logic              buf_full;
  logic              found;
  logic [ValueW-1:0] head_data;
  result_t           out_res;
  mode_e             mode;

  logic [ValueW-1:0] data   [CAPACITY];
  logic              prior  [CAPACITY+1];

  assign mode       = mode_e'(s_tuser_i);
  assign s_tready_o = (state_q == S_IDLE) && !buf_full && !res_push_q;
  assign accept     = s_tvalid_i && s_tready_o;
  assign head_data  = data[0];
  assign found      = prior[CAPACITY];
  assign prior[0]   = 1'b0;

  // fill as reported: count modulo 256
  function automatic logic [FillW-1:0] to_fill(input logic [CW-1:0] c);
    logic [CW+FillW-1:0] ext;
    ext = {{FillW{1'b0}}, c};
    return ext[FillW-1:0];
  endfunction

  // command broadcast to the chain
  always_comb begin
    ctrl.cmd   = CELL_HOLD;
    ctrl.value = s_tdata_i;
    if (state_q == S_REMOVE) begin
      ctrl.cmd   = CELL_REMOVE;
      ctrl.value = srch_q;
    end else if (accept) begin
      unique case (mode)
        MODE_PUSH:   ctrl.cmd = CELL_LOAD;
        MODE_POP:    ctrl.cmd = (count_q != '0) ? CELL_SHIFT : CELL_HOLD;
        MODE_REMOVE: ctrl.cmd = CELL_MATCH;
        default:     ctrl.cmd = CELL_HOLD;
      endcase
    end
  end

  // chain of entry cells, head at cell 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic [ValueW-1:0] next_data;

    if (i == CAPACITY - 1) begin : g_last
      assign next_data = '0;
    end else begin : g_mid
      assign next_data = data[i+1];
    end

    bqr_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .load_en_i   (count_q == IDX),
      .in_range_i  (IDX < count_q),
      .next_data_i (next_data),
      .prior_i     (prior[i]),
      .data_o      (data[i]),
      .prior_o     (prior[i+1])
    );
  end

  // next control state, fill count and result
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    srch_d     = srch_q;
    res_push_d = 1'b0;
    res_d      = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_push_d   = 1'b1;
          res_d.status = ST_DONE;
          res_d.value  = '0;
          res_d.fill   = to_fill(count_q);
          unique case (mode)
            MODE_PUSH: begin
              if (count_q == CW'(CAPACITY)) begin
                res_d.status = ST_FULL;
              end else begin
                count_d    = count_q + 1'b1;
                res_d.fill = to_fill(count_q + 1'b1);
              end
            end
            MODE_POP: begin
              if (count_q == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                count_d     = count_q - 1'b1;
                res_d.value = head_data;
                res_d.fill  = to_fill(count_q - 1'b1);
              end
            end
            MODE_REMOVE: begin
              res_push_d = 1'b0;
              srch_d     = s_tdata_i;
              state_d    = S_REMOVE;
            end
            default: begin
            end
          endcase
        end
      end
      S_REMOVE: begin
        res_push_d = 1'b1;
        state_d    = S_IDLE;
        if (found) begin
          count_d      = count_q - 1'b1;
          res_d.status = ST_DONE;
          res_d.value  = srch_q;
          res_d.fill   = to_fill(count_q - 1'b1);
        end else begin
          res_d.status = ST_NOTFOUND;
          res_d.value  = '0;
          res_d.fill   = to_fill(count_q);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state, fill count and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      res_push_q <= 1'b0;
      srch_q     <= '0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      res_push_q <= res_push_d;
      srch_q     <= srch_d;
      res_q      <= res_d;
    end
  end

  // result buffer towards the master side
  bqr_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push_q),
    .res_i   (res_q),
    .full_o  (buf_full),
    .valid_o (m_tvalid_o),
    .ready_i (m_tready_i),
    .res_o   (out_res)
  );

  assign m_tdata_o = {out_res.fill, out_res.value};
  assign m_tuser_o = out_res.status;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_remove_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_REMOVE |=> state_q == S_IDLE && res_push_q)
    else $error("remove did not finish with a result");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REMOVE || res_push_q) |-> !s_tready_o)
    else $error("input transfer taken while an operation is open");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_push_q && state_q == S_IDLE && !accept |=> $stable(count_q))
    else $error("fill count moved without an operation");
`endif

endmodule

`default_nettype wire
